[hdl/fsd_pkg.sv]
// ----------------------------------------------------------------------------
// fsd_pkg - shared types and constants for the one-bit RGB ditherer
// Pixel, error and position flag types, register codes and diffusion weights.
// ----------------------------------------------------------------------------
`default_nettype none

package fsd_pkg;

   localparam int MAX_WIDTH_DEF = 64;

   localparam int CFG_WIDTH_W  = 7;
   localparam int CFG_HEIGHT_W = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 11;

   localparam logic [CFG_WIDTH_W-1:0]  FRAME_WIDTH_RST  = 7'd16;
   localparam logic [CFG_HEIGHT_W-1:0] FRAME_HEIGHT_RST = 11'd16;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   localparam int QUEUE_DEPTH = 2;

   // Floyd-Steinberg weights over 16
   localparam logic [2:0] W_RIGHT       = 3'd7;
   localparam logic [2:0] W_LOWER_LEFT  = 3'd3;
   localparam logic [2:0] W_BELOW       = 3'd5;
   localparam logic [2:0] W_LOWER_RIGHT = 3'd1;

   localparam logic [7:0] THRESHOLD  = 8'd127;
   localparam logic [7:0] FULL_SCALE = 8'd255;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_pixel_type;

   typedef struct packed {
      logic signed [7:0] red;
      logic signed [7:0] green;
      logic signed [7:0] blue;
   } rgb_err_type;

   typedef struct packed {
      logic above;
      logic has_left;
      logic has_right;
      logic frame_end;
   } pos_flags_type;

   typedef struct packed {
      rgb_pixel_type pixel;
      pos_flags_type flags;
   } pixel_item_type;

endpackage

`default_nettype wire

[hdl/fsd_front.sv]
// ----------------------------------------------------------------------------
// fsd_front - pixel intake and position classification
// Tracks column and row, works out edge flags and pushes items to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_front
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  [7:0]                       req_in_red,
   input  wire  [7:0]                       req_in_green,
   input  wire  [7:0]                       req_in_blue,
   input  wire  [CFG_WIDTH_W-1:0]           frame_width,
   input  wire  [CFG_HEIGHT_W-1:0]          frame_height,
   input  wire                              queue_full,
   output logic                             push,
   output pixel_item_type                   push_item,
   output logic [$clog2(MAX_WIDTH)-1:0]     push_col
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W  = (WCNT_W > CFG_WIDTH_W) ? WCNT_W : CFG_WIDTH_W;

   logic [COL_W-1:0]        column_count_ff, column_count_in;
   logic [CFG_HEIGHT_W-1:0] row_count_ff, row_count_in;

   logic [CMP_W-1:0]        width_ext, width_eff, col_ext, col_eff;
   logic [CFG_HEIGHT_W-1:0] height_eff;
   logic                    end_row, end_frame;

   always_comb begin
      width_ext = CMP_W'(frame_width);
      if (width_ext == '0) begin
         width_eff = CMP_W'(1);
      end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      height_eff = (frame_height == '0) ? CFG_HEIGHT_W'(1) : frame_height;

      col_ext = CMP_W'(column_count_ff);
      col_eff = (col_ext >= width_eff) ? width_eff - CMP_W'(1) : col_ext;

      end_row   = (col_ext + CMP_W'(1)) >= width_eff;
      end_frame = end_row && ((row_count_ff + CFG_HEIGHT_W'(1)) >= height_eff);
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign push_col  = col_eff[COL_W-1:0];

   always_comb begin
      push_item.pixel.red       = req_in_red;
      push_item.pixel.green     = req_in_green;
      push_item.pixel.blue      = req_in_blue;
      push_item.flags.above     = (row_count_ff != '0);
      push_item.flags.has_left  = (col_eff != '0);
      push_item.flags.has_right = (col_eff + CMP_W'(1)) < width_eff;
      push_item.flags.frame_end = end_frame;
   end

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (push) begin
         if (end_row) begin
            column_count_in = '0;
            row_count_in    = end_frame ? '0 : row_count_ff + CFG_HEIGHT_W'(1);
         end else begin
            column_count_in = column_count_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   a_col_in_line: assert property (@(posedge clock) disable iff (reset)
      int'(column_count_ff) < MAX_WIDTH)
      else $error("column counter beyond line store");

endmodule

`default_nettype wire

[hdl/fsd_queue.sv]
// ----------------------------------------------------------------------------
// fsd_queue - short item queue between intake and error diffusion
// Small register FIFO so either side can stall without blocking the other.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_queue
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push,
   input  pixel_item_type                   push_item,
   input  wire  [$clog2(MAX_WIDTH)-1:0]     push_col,
   output logic                             full,
   input  wire                              pop,
   output logic                             head_valid,
   output pixel_item_type                   head_item,
   output logic [$clog2(MAX_WIDTH)-1:0]     head_col
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);

   pixel_item_type     item_ff [QUEUE_DEPTH];
   logic [COL_W-1:0]   col_ff  [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      logic [QPTR_W-1:0] n;
      n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
      return n;
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = item_ff[rd_ptr_ff];
   assign head_col   = col_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= push_item;
         col_ff[wr_ptr_ff]  <= push_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue read while empty");

endmodule

`default_nettype wire

[hdl/fsd_back.sv]
// ----------------------------------------------------------------------------
// fsd_back - error diffusion and one-bit quantisation
// Reads the row error line, adds the diffused terms, quantises and writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module fsd_back
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              head_valid,
   input  pixel_item_type                   head_item,
   input  wire  [$clog2(MAX_WIDTH)-1:0]     head_col,
   output logic                             pop,
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_out_red,
   output logic                             rsp_out_green,
   output logic                             rsp_out_blue,
   output logic                             rsp_frame_end
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   rgb_err_type        line_mem [MAX_WIDTH];

   logic               b1_valid_ff, b1_valid_in;
   pixel_item_type     b1_item_ff;
   logic [COL_W-1:0]   b1_col_ff;
   rgb_err_type        rd_a_ff, rd_b_ff;
   rgb_err_type        held_ff, held_in;
   rgb_err_type        carry_ff, carry_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [2:0]         rsp_bits_ff;
   logic               rsp_end_ff;

   logic               b1_fire;
   logic [COL_W-1:0]   rd_addr_a, rd_addr_b;
   rgb_err_type        err_now;
   logic [2:0]         bits_now;
   logic [8:0]         q_red, q_green, q_blue;

   // floor((e * k) / 16)
   function automatic logic signed [6:0] spread(input logic signed [7:0] e,
                                                input logic [2:0] k);
      logic signed [11:0] p;
      p = $signed({{4{e[7]}}, e}) * $signed({9'd0, k});
      return p[10:4];
   endfunction

   function automatic logic [7:0] add_clamp(input logic [7:0] a,
                                            input logic signed [6:0] d);
      logic signed [9:0] s;
      logic [7:0]        r;
      s = $signed({2'b00, a}) + $signed({{3{d[6]}}, d});
      if (s < 10'sd0) begin
         r = 8'd0;
      end else if (s > 10'sd255) begin
         r = 8'd255;
      end else begin
         r = s[7:0];
      end
      return r;
   endfunction

   // returns {bit, error}
   function automatic logic [8:0] quantise(input logic [7:0] pix,
                                           input logic signed [7:0] ul,
                                           input logic signed [7:0] up,
                                           input logic signed [7:0] ur,
                                           input logic signed [7:0] lf,
                                           input pos_flags_type f);
      logic [7:0] v;
      logic [8:0] r;
      v = pix;
      if (f.above) begin
         if (f.has_left) begin
            v = add_clamp(v, spread(ul, W_LOWER_RIGHT));
         end
         v = add_clamp(v, spread(up, W_BELOW));
         if (f.has_right) begin
            v = add_clamp(v, spread(ur, W_LOWER_LEFT));
         end
      end
      if (f.has_left) begin
         v = add_clamp(v, spread(lf, W_RIGHT));
      end
      if (v > THRESHOLD) begin
         r = {1'b1, v - FULL_SCALE};
      end else begin
         r = {1'b0, v};
      end
      return r;
   endfunction

   always_comb begin
      q_red   = quantise(b1_item_ff.pixel.red, held_ff.red, rd_a_ff.red,
                         rd_b_ff.red, carry_ff.red, b1_item_ff.flags);
      q_green = quantise(b1_item_ff.pixel.green, held_ff.green, rd_a_ff.green,
                         rd_b_ff.green, carry_ff.green, b1_item_ff.flags);
      q_blue  = quantise(b1_item_ff.pixel.blue, held_ff.blue, rd_a_ff.blue,
                         rd_b_ff.blue, carry_ff.blue, b1_item_ff.flags);
      err_now.red   = q_red[7:0];
      err_now.green = q_green[7:0];
      err_now.blue  = q_blue[7:0];
      bits_now      = {q_red[8], q_green[8], q_blue[8]};
   end

   assign b1_fire   = b1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign pop       = head_valid && (!b1_valid_ff || b1_fire);
   assign rd_addr_a = head_col;
   assign rd_addr_b = head_item.flags.has_right ? head_col + COL_W'(1) : head_col;

   // line store, write-first towards the read that issues in the same cycle
   always_ff @(posedge clock) begin
      if (b1_fire) begin
         line_mem[b1_col_ff] <= err_now;
      end
      if (pop) begin
         rd_a_ff <= (b1_fire && (b1_col_ff == rd_addr_a)) ? err_now : line_mem[rd_addr_a];
         rd_b_ff <= (b1_fire && (b1_col_ff == rd_addr_b)) ? err_now : line_mem[rd_addr_b];
      end
   end

   always_comb begin
      b1_valid_in  = pop || (b1_valid_ff && !b1_fire);
      held_in      = b1_fire ? rd_a_ff : held_ff;
      carry_in     = b1_fire ? err_now : carry_ff;
      rsp_valid_in = b1_fire || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_item_ff <= head_item;
         b1_col_ff  <= head_col;
      end
      if (b1_fire) begin
         rsp_bits_ff <= bits_now;
         rsp_end_ff  <= b1_item_ff.flags.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         held_ff      <= '0;
         carry_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         b1_valid_ff  <= b1_valid_in;
         held_ff      <= held_in;
         carry_ff     <= carry_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_bits_ff[2];
   assign rsp_out_green = rsp_bits_ff[1];
   assign rsp_out_blue  = rsp_bits_ff[0];
   assign rsp_frame_end = rsp_end_ff;

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      b1_fire |-> (err_now.red != 8'sh80 && err_now.green != 8'sh80 &&
                   err_now.blue != 8'sh80))
      else $error("quantisation error out of range");

   a_b1_hold: assert property (@(posedge clock) disable iff (reset)
      (b1_valid_ff && !b1_fire) |=> (b1_valid_ff && $stable(b1_col_ff)))
      else $error("diffusion stage lost a held item");

endmodule

`default_nettype wire

[hdl/floyd_steinberg_one_bit_rgb.sv]
// Path: an accepted pixel goes through the queue hop and the line store read,
// then is diffused and quantised into the output register.
// Throughput: one pixel per clock while rsp_stall is low, set by the error carry loop.
// Reset: position, carried errors and queue cleared; width and height set to
// 16. The row error line is not cleared and holds nothing until written.
// ----------------------------------------------------------------------------
// floyd_steinberg_one_bit_rgb - streaming one-bit RGB Floyd-Steinberg ditherer
// Register file, intake, item queue and diffusion back end.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_one_bit_rgb
   import fsd_pkg::*;
#(
   parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [7:0]                req_in_red,
   input  wire  [7:0]                req_in_green,
   input  wire  [7:0]                req_in_blue,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic                      rsp_out_red,
   output logic                      rsp_out_green,
   output logic                      rsp_out_blue,
   output logic                      rsp_frame_end,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire  [CSR_INDEX_W-1:0]    csr_index,
   input  wire  [CSR_DATA_W-1:0]     csr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);

   logic [CFG_WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [CFG_HEIGHT_W-1:0] frame_height_ff, frame_height_in;

   logic               queue_full, push, pop, head_valid;
   pixel_item_type     push_item, head_item;
   logic [COL_W-1:0]   push_col, head_col;

   assign csr_ready = 1'b1;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  frame_width_in  = csr_data[CFG_WIDTH_W-1:0];
            CSR_FRAME_HEIGHT: frame_height_in = csr_data[CFG_HEIGHT_W-1:0];
            default:          frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
      end
   end

   fsd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_red   (req_in_red),
      .req_in_green (req_in_green),
      .req_in_blue  (req_in_blue),
      .frame_width  (frame_width_ff),
      .frame_height (frame_height_ff),
      .queue_full   (queue_full),
      .push         (push),
      .push_item    (push_item),
      .push_col     (push_col)
   );

   fsd_queue #(.MAX_WIDTH(MAX_WIDTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_col   (push_col),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_col   (head_col)
   );

   fsd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .head_col      (head_col),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

`default_nettype wire

[test/floyd_steinberg_one_bit_rgb_tb.sv]
// ----------------------------------------------------------------------------
// floyd_steinberg_one_bit_rgb_tb - self-checking bench for the RGB ditherer
// Streams pixels through the block with random gaps and output stalls. A
// directed table covers the extremes, the frame edges, the out-of-range
// width and height settings and size changes mid-frame. A long random run
// follows. Each result transfer is checked against its row's typed result or
// else a bench error-diffusion model that follows frame position and settings.
// ----------------------------------------------------------------------------
`default_nettype none

module floyd_steinberg_one_bit_rgb_tb;
   import fsd_pkg::*;

   localparam int LINE_DEPTH     = MAX_WIDTH_DEF;
   localparam int PIXEL_TOTAL    = 1750;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TABLE_ROWS     = 29;

   typedef struct packed {
      logic red;
      logic green;
      logic blue;
      logic frame_end;
   } mono_pixel_type;

   typedef struct packed {
      logic                  is_csr;
      csr_index_type         sel;
      logic [CSR_DATA_W-1:0] value;
      logic [7:0]            red;
      logic [7:0]            green;
      logic [7:0]            blue;
      logic                  typed;
      mono_pixel_type        want;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_in_red = '0;
   logic [7:0]            req_in_green = '0;
   logic [7:0]            req_in_blue = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_out_red;
   logic                  rsp_out_green;
   logic                  rsp_out_blue;
   logic                  rsp_frame_end;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // bench copy of the block state
   logic [CFG_WIDTH_W-1:0]  width_setting = FRAME_WIDTH_RST;
   logic [CFG_HEIGHT_W-1:0] height_setting = FRAME_HEIGHT_RST;
   logic signed [7:0]       line_err [LINE_DEPTH][3];
   logic signed [7:0]       carry_err [3];
   logic signed [7:0]       upper_left_err [3];
   int                      col_count;
   int                      row_count;
   int                      line_filled;

   mono_pixel_type dithered_due [$];
   stim_row_type   typed_due [$];
   stim_row_type   directed_rows [TABLE_ROWS];
   int             pixels_sent = 0;
   int             results_seen = 0;
   int             failures = 0;
   int             send_calm = 0;
   int             recv_calm = 0;
   int             quiet_cycles = 0;

   floyd_steinberg_one_bit_rgb u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_frame_end (rsp_frame_end),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int eff_width(input logic [CFG_WIDTH_W-1:0] raw);
      if (raw == 0) return 1;
      if (raw > LINE_DEPTH) return LINE_DEPTH;
      return int'(raw);
   endfunction

   function automatic int add_clamped(input int acc, input int err, input int wgt);
      int s;
      s = acc + ((err * wgt) >>> 4);
      if (s < 0) return 0;
      if (s > 255) return 255;
      return s;
   endfunction

   function automatic mono_pixel_type dither_pixel(input logic [7:0] red, green, blue);
      int                w;
      int                h;
      int                col;
      int                v;
      logic [7:0]        level [3];
      logic signed [7:0] fresh [3];
      logic [2:0]        bits;
      logic              row_done;
      mono_pixel_type    res;
      w = eff_width(width_setting);
      h = (height_setting == 0) ? 1 : int'(height_setting);
      col = (col_count >= w) ? w - 1 : col_count;
      level[0] = red;
      level[1] = green;
      level[2] = blue;
      for (int c = 0; c < 3; c++) begin
         v = int'(level[c]);
         if (row_count > 0) begin
            if (col > 0) v = add_clamped(v, upper_left_err[c], W_LOWER_RIGHT);
            v = add_clamped(v, line_err[col][c], W_BELOW);
            if (col + 1 < w) v = add_clamped(v, line_err[col + 1][c], W_LOWER_LEFT);
         end
         if (col > 0) v = add_clamped(v, carry_err[c], W_RIGHT);
         bits[c] = (v > int'(THRESHOLD));
         fresh[c] = bits[c] ? 8'(v - int'(FULL_SCALE)) : 8'(v);
      end
      for (int c = 0; c < 3; c++) begin
         upper_left_err[c] = line_err[col][c];
         line_err[col][c] = fresh[c];
         carry_err[c] = fresh[c];
      end
      if (col + 1 > line_filled) line_filled = col + 1;
      row_done = (col_count + 1 >= w);
      res.red = bits[0];
      res.green = bits[1];
      res.blue = bits[2];
      res.frame_end = row_done && (row_count + 1 >= h);
      if (row_done) begin
         col_count = 0;
         row_count = res.frame_end ? 0 : row_count + 1;
      end else begin
         col_count++;
      end
      return res;
   endfunction

   function automatic int draw_wait(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 50);
         return 0;
      end
      return $urandom_range(0, 13);
   endfunction

   function automatic logic [7:0] random_level();
      case ($urandom_range(0, 7))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd127;
         3: return 8'd128;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic check_field(input string name, input logic want, input logic got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (results_seen < pixels_sent) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [CSR_DATA_W-1:0] value);
      csr_index <= sel;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic send_pixel(input stim_row_type row);
      int gap;
      gap = draw_wait(send_calm);
      csr_valid <= 1'b0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      typed_due.push_back(row);
      req_valid <= 1'b1;
      req_in_red <= row.red;
      req_in_green <= row.green;
      req_in_blue <= row.blue;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // model update and result check, both sampled at the clock edge
   always @(posedge clock) begin
      mono_pixel_type predicted;
      mono_pixel_type got;
      stim_row_type   row;
      if (reset) begin
         width_setting = FRAME_WIDTH_RST;
         height_setting = FRAME_HEIGHT_RST;
         col_count = 0;
         row_count = 0;
         line_filled = 0;
         for (int c = 0; c < 3; c++) begin
            carry_err[c] = '0;
            upper_left_err[c] = '0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_setting = csr_data[CFG_WIDTH_W-1:0];
               CSR_FRAME_HEIGHT: height_setting = csr_data[CFG_HEIGHT_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            predicted = dither_pixel(req_in_red, req_in_green, req_in_blue);
            row = typed_due.pop_front();
            dithered_due.push_back(row.typed ? row.want : predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            got = '{rsp_out_red, rsp_out_green, rsp_out_blue, rsp_frame_end};
            if (dithered_due.size() == 0) begin
               $error("result transfer with nothing expected");
               failures++;
            end else begin
               predicted = dithered_due.pop_front();
               check_field("out_red", predicted.red, got.red);
               check_field("out_green", predicted.green, got.green);
               check_field("out_blue", predicted.blue, got.blue);
               check_field("frame_end", predicted.frame_end, got.frame_end);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = draw_wait(recv_calm);
         if (stall > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      logic [CFG_WIDTH_W-1:0]  wv;
      logic [CFG_HEIGHT_W-1:0] hv;
      stim_row_type            row;
      int                      phase_len;

      // sel/value for register rows; levels and typed result for pixel rows
      directed_rows = '{
         '{1'b1, CSR_FRAME_WIDTH,  11'd4,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b1, CSR_FRAME_HEIGHT, 11'd2,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd255, 8'd0,   8'd128, 1'b1, 4'b1010},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd0,   8'd255, 8'd127, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd127, 8'd128, 8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd255, 8'd255, 8'd255, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd128, 8'd127, 8'd255, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd200, 8'd60,  8'd10,  1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd1,   8'd254, 8'd100, 1'b0, 4'b0000},
         // zero width and height act as one: every pixel ends a frame
         '{1'b1, CSR_FRAME_WIDTH,  11'd0,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b1, CSR_FRAME_HEIGHT, 11'd0,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd128, 8'd127, 8'd0,   1'b1, 4'b1001},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd0,   8'd255, 8'd255, 1'b1, 4'b0111},
         // oversize width clamps to the line length
         '{1'b1, CSR_FRAME_WIDTH,  11'd127,  8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b1, CSR_FRAME_HEIGHT, 11'd2047, 8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd255, 8'd255, 8'd255, 1'b1, 4'b1110},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd90,  8'd170, 8'd30,  1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd0,   8'd127, 8'd255, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd64,  8'd192, 8'd128, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd255, 8'd1,   8'd127, 1'b0, 4'b0000},
         // shrink mid-row: column already past the new edge, row ends
         '{1'b1, CSR_FRAME_WIDTH,  11'd2,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd140, 8'd20,  8'd250, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd127, 8'd128, 8'd64,  1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd33,  8'd222, 8'd180, 1'b0, 4'b0000},
         // height cut below the current row: frame ends with this row
         '{1'b1, CSR_FRAME_HEIGHT, 11'd1,    8'd0,   8'd0,   8'd0,   1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd255, 8'd0,   8'd77,  1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd12,  8'd255, 8'd128, 1'b0, 4'b0000},
         '{1'b0, CSR_FRAME_WIDTH,  11'd0,    8'd200, 8'd200, 8'd0,   1'b0, 4'b0000}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < TABLE_ROWS; i++) begin
         if (directed_rows[i].is_csr) begin
            wait_drained();
            write_csr(directed_rows[i].sel, directed_rows[i].value);
         end else begin
            send_pixel(directed_rows[i]);
         end
      end

      while (pixels_sent < PIXEL_TOTAL) begin
         wait_drained();
         if ($urandom_range(0, 1) == 1) begin
            case ($urandom_range(0, 9))
               0: wv = 7'd0;
               1: wv = 7'd64;
               2: wv = 7'd127;
               3: wv = 7'($urandom);
               default: wv = 7'($urandom_range(1, 8));
            endcase
            // mid-frame growth may only reach line entries already written
            if (row_count > 0 && eff_width(wv) > line_filled) wv = 7'(line_filled);
            write_csr(CSR_FRAME_WIDTH, {4'($urandom), wv});
         end
         if ($urandom_range(0, 1) == 1 || row_count >= 900) begin
            case ($urandom_range(0, 9))
               0: hv = 11'd0;
               1: hv = 11'd1024;
               2: hv = 11'd2047;
               3: hv = 11'($urandom);
               default: hv = 11'($urandom_range(1, 6));
            endcase
            if (row_count >= 900) hv = 11'd1;
            write_csr(CSR_FRAME_HEIGHT, hv);
         end
         phase_len = $urandom_range(1, 120);
         repeat (phase_len) begin
            row = '0;
            row.red = random_level();
            row.green = random_level();
            row.blue = random_level();
            send_pixel(row);
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (dithered_due.size() != 0) begin
         $error("%0d results never arrived", dithered_due.size());
         failures++;
      end
      if (failures == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/fsd_pkg.sv
hdl/fsd_front.sv
hdl/fsd_queue.sv
hdl/fsd_back.sv
hdl/floyd_steinberg_one_bit_rgb.sv
test/floyd_steinberg_one_bit_rgb_tb.sv
